[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check on clk, held off while arst_n is low.
`define BVEE_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("bvee check failed");

// Condition that must never be seen at a clock edge.
`define BVEE_NEVER(label, expr) \
	`BVEE_ASSERT(label, !(expr))

`endif

[rtl/bvee_pkg.sv]
package bvee_pkg;

	localparam int CHAR_W = 7;
	localparam int MAX_RUN = 5;
	localparam int RUN_LEN_W = 3;

	localparam logic [CHAR_W-1:0] CH_BSLASH = 7'd92;
	localparam logic [CHAR_W-1:0] CH_CARET = 7'd94;
	localparam logic [CHAR_W-1:0] CH_QMARK = 7'd63;
	localparam logic [CHAR_W-1:0] CH_ZERO = 7'd48;
	localparam logic [CHAR_W-1:0] CH_M = 7'd77;
	localparam logic [CHAR_W-1:0] CH_DASH = 7'd45;
	localparam logic [CHAR_W-1:0] CH_S = 7'd115;
	localparam logic [CHAR_W-1:0] CH_SPACE = 7'd32;
	localparam logic [CHAR_W-1:0] CH_DEL = 7'd127;
	localparam logic [CHAR_W-1:0] CH_FIRST_PRINT = 7'd33;
	localparam logic [CHAR_W-1:0] CH_LAST_PRINT = 7'd126;

	// Characters go out from index 0 upward.
	typedef struct packed {
		logic [MAX_RUN-1:0][CHAR_W-1:0] chars;
		logic [RUN_LEN_W-1:0] len;
	} run_t;

	// Letter for the C-style escapes of bytes 7..13.
	function automatic logic [CHAR_W-1:0] ctl_letter(input logic [3:0] c);
		logic [CHAR_W-1:0] l;
		case (c)
			4'd7: l = 7'd97;   // a
			4'd8: l = 7'd98;   // b
			4'd9: l = 7'd116;  // t
			4'd10: l = 7'd110; // n
			4'd11: l = 7'd118; // v
			4'd12: l = 7'd102; // f
			4'd13: l = 7'd114; // r
			default: l = 7'd97;
		endcase
		return l;
	endfunction

endpackage

[rtl/bvee_decode.sv]
module bvee_decode
	import bvee_pkg::*;
(
	input  logic [7:0] in_byte,
	output run_t       run
);

	logic [CHAR_W-1:0] c;
	logic              high;
	logic [CHAR_W-1:0] t0;
	logic [CHAR_W-1:0] t1;
	logic              tail_two;

	assign c = in_byte[6:0];
	assign high = in_byte[7];

	// Tail: the whole form of a low byte, or what follows \M- for a high one.
	always_comb begin
		t0 = c;
		t1 = '0;
		tail_two = 1'b0;
		if (c >= CH_FIRST_PRINT && c <= CH_LAST_PRINT) begin
			if (!high && (c == CH_BSLASH || c == CH_CARET)) begin
				t0 = CH_BSLASH;
				t1 = c;
				tail_two = 1'b1;
			end
		end else if (c == CH_DEL) begin
			t0 = CH_CARET;
			t1 = CH_QMARK;
			tail_two = 1'b1;
		end else if (c == CH_SPACE) begin
			t0 = CH_BSLASH;
			t1 = CH_S;
			tail_two = 1'b1;
		end else if (!high && c == '0) begin
			t0 = CH_BSLASH;
			t1 = CH_ZERO;
			tail_two = 1'b1;
		end else if (!high && c >= 7'd7 && c <= 7'd13) begin
			t0 = CH_BSLASH;
			t1 = ctl_letter(c[3:0]);
			tail_two = 1'b1;
		end else begin
			// remaining control codes: caret form
			t0 = CH_CARET;
			t1 = c + 7'd64;
			tail_two = 1'b1;
		end
	end

	always_comb begin
		run.chars = '0;
		if (high) begin
			run.chars[0] = CH_BSLASH;
			run.chars[1] = CH_M;
			run.chars[2] = CH_DASH;
			run.chars[3] = t0;
			run.chars[4] = t1;
			run.len = tail_two ? RUN_LEN_W'(5) : RUN_LEN_W'(4);
		end else begin
			run.chars[0] = t0;
			run.chars[1] = t1;
			run.len = tail_two ? RUN_LEN_W'(2) : RUN_LEN_W'(1);
		end
	end

endmodule

[rtl/bvee_serializer.sv]
module bvee_serializer
	import bvee_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              run_valid,
	input  run_t              run,
	output logic              load,
	output logic              char_valid,
	input  logic              char_ready,
	output logic [CHAR_W-1:0] char_out,
	output logic              char_last
);

	logic [MAX_RUN-1:0][CHAR_W-1:0] chars_q;
	logic [RUN_LEN_W-1:0]           cnt_q;

	assign char_valid = cnt_q != '0;
	assign char_last = cnt_q == RUN_LEN_W'(1);
	assign char_out = chars_q[0];
	// take a new run when empty or when the last character leaves now
	assign load = run_valid && (!char_valid || (char_ready && char_last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= run.len;
		end else if (char_valid && char_ready) begin
			cnt_q <= cnt_q - RUN_LEN_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			chars_q <= run.chars;
		end else if (char_valid && char_ready) begin
			chars_q <= {CHAR_W'(0), chars_q[MAX_RUN-1:1]};
		end
	end

endmodule

[rtl/byte_visible_escape_encoder.sv]
// Visible escape encoder: each byte accepted on s_axis comes out on m_axis
// as one to five printable characters (one per request, tlast on the final
// one). Output runs at one character per cycle while m_axis_tready is high;
// a byte takes one character (plain printable), two (short escape), or four
// or five (\M- forms), so the character serializer sets the throughput.
// A byte passes the input register, then the serializer's character register.
// The input register takes the next byte while the current run is still draining.
`include "assert_macros.svh"

module byte_visible_escape_encoder
	import bvee_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [7:0] in_byte
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // [6:0] out_char, [7] zero
	output logic       m_axis_tlast   // last_char
);

	logic [7:0]        byte_s1;
	logic              valid_s1;
	run_t              run;
	logic              load;
	logic [CHAR_W-1:0] char_out;

	assign s_axis_tready = !valid_s1 || load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	bvee_decode u_decode (
		.in_byte (byte_s1),
		.run     (run)
	);

	bvee_serializer u_ser (
		.clk        (clk),
		.arst_n     (arst_n),
		.run_valid  (valid_s1),
		.run        (run),
		.load       (load),
		.char_valid (m_axis_tvalid),
		.char_ready (m_axis_tready),
		.char_out   (char_out),
		.char_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {1'b0, char_out};

	`BVEE_ASSERT(a_load_when_free, load |-> (!m_axis_tvalid || (m_axis_tready && m_axis_tlast)))
	`BVEE_ASSERT(a_char_printable, m_axis_tvalid |-> (char_out >= CH_FIRST_PRINT && char_out <= CH_LAST_PRINT))
	`BVEE_ASSERT(a_s1_holds, (valid_s1 && !load) |=> (valid_s1 && $stable(byte_s1)))
	`BVEE_NEVER(a_run_len_range, valid_s1 && (run.len == '0 || run.len > RUN_LEN_W'(MAX_RUN)))

endmodule
